>>> src/cmzn_pkg.sv
// Shared constants for the column min-max / z-score normalizer.
// Result status codes, configuration register indexes and the Q16.16 value one half.
// No dependencies.
package cmzn_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_TLOW  = 2'd1;
  localparam logic [1:0] CFG_THIGH = 2'd2;

  localparam int unsigned HALF_Q16 = 32768;

endpackage

>>> src/column_minmax_zscore_normalizer_core.sv
// Column normalizer core: loads a column of Q16.16 samples, then emits each
// sample min-max scaled or z-score standardized. Uses cmzn_pkg.
// Built around one iterative multiplier, divider and square-root sequencer.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------
//  input    | start & !busy      | sample[31:0], last
//  result   | done (one cycle)   | scaled_value[31:0], status, final_res
//  config   | cfg_write          | cfg_index[1:0], cfg_data[31:0]
//
// Loading accepts one sample per cycle while busy is low. After the beat
// marked last, busy stays high while the run is computed and emitted.
// Z-score mode makes a variance pass of multiplies over the samples, then a
// variance divide and a square root, then a multiply and a bit-serial divide
// per defined result. Min-max mode does one multiply and one divide per
// result unless the column is constant.
// Synchronous reset clears control state and configuration; the store needs
// no clearing. Results cannot be stalled; each shows for exactly one cycle.
module column_minmax_zscore_normalizer_core #(
  parameter int MAX_SAMPLES  = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  input  logic [31:0] sample,
  input  logic        last,
  output logic        busy,
  output logic        done,
  output logic [31:0] scaled_value,
  output logic [1:0]  status,
  output logic        final_res
);
  import cmzn_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = SW + 7;
  localparam int DW   = SW + 8;
  localparam int WW   = 2 * SW + 24;
  localparam int MBW  = (DW > 34) ? DW : 34;
  localparam int RW   = SW + 12;
  localparam int VW   = SW + 36;
  localparam int DCW  = $clog2(WW + 2);

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [DCW-1:0] DIV_STEPS = DCW'(WW + 1);
  localparam logic [CW-1:0]  CAP = CW'(MAX_SAMPLES);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_READ, S_DISP, S_MUL_NX, S_CALC, S_MUL_DD, S_DIV_V,
    S_SQRT, S_DIV_Z, S_MUL_MM, S_DIV_M, S_EMIT
  } state_t;

  state_t state;

  logic               scaling_mode;
  logic signed [31:0] target_low, target_high;

  logic signed [SW-1:0] mem [MAX_SAMPLES];
  logic signed [SW-1:0] rdata;

  logic [CW-1:0]         count;
  logic signed [SUMW-1:0] run_sum;
  logic signed [SW-1:0]  run_min, run_max;
  logic                  ovf;

  logic [AW-1:0]        idx;
  logic                 pass_z, zundef;
  logic [WW-1:0]        var_acc;
  logic [RW-1:0]        root;
  logic signed [DW-1:0] d_val;

  logic [WW-1:0]  m_a, m_acc;
  logic [MBW-1:0] m_b;

  logic [WW:0]    dv_num, dv_den, dv_quo;
  logic [WW+1:0]  dv_rem;
  logic [DCW-1:0] dv_cnt;

  logic [WW-1:0] sq_n, sq_res, sq_bit;

  logic signed [VW-1:0] res_val;
  logic                 res_sat;

  // input decode
  logic [47:0]          samp_ext;
  logic signed [SW-1:0] x_in;
  logic                 accept, load_wr;

  assign samp_ext = {16'd0, sample};
  assign x_in     = samp_ext[SW-1:0];
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign load_wr  = accept && (count < CAP);

  always_ff @(posedge clk) begin
    if (load_wr) mem[count[AW-1:0]] <= x_in;
    rdata <= mem[idx];
  end

  // datapath terms
  logic                 x_neg, d_neg, is_final;
  logic [SW-1:0]        x_mag;
  logic [DW-1:0]        nx_mag, d_mag;
  logic signed [DW-1:0] nx_s, d_next;
  logic signed [32:0]   span;
  logic [32:0]          span_mag;
  logic [SW:0]          diff, rng;
  logic [WW-1:0]        var_sum;
  logic [WW+1:0]        rem_sh;
  logic                 dv_ge;
  logic [WW-1:0]        sq_t;
  logic [WW:0]          z_lim;
  logic                 z_sat, mm_sat;
  logic signed [VW-1:0] zq, z_val, qm, mm_off, mm_sum, mm_val;

  assign x_neg    = rdata[SW-1];
  assign x_mag    = x_neg ? (~rdata + 1'b1) : rdata;
  assign nx_mag   = m_acc[DW-1:0];
  assign nx_s     = x_neg ? -$signed(nx_mag) : $signed(nx_mag);
  assign d_next   = nx_s - DW'(run_sum);
  assign d_neg    = d_val[DW-1];
  assign d_mag    = d_neg ? (~d_val + 1'b1) : d_val;
  assign span     = 33'(target_high) - 33'(target_low);
  assign span_mag = span[32] ? (~span + 1'b1) : span;
  assign diff     = (SW+1)'(rdata) - (SW+1)'(run_min);
  assign rng      = (SW+1)'(run_max) - (SW+1)'(run_min);
  assign var_sum  = var_acc + m_acc;
  assign is_final = (CW'(idx) == count - CW'(1));

  assign rem_sh = {dv_rem[WW:0], dv_num[WW]};
  assign dv_ge  = (rem_sh >= {1'b0, dv_den});
  assign sq_t   = sq_res + sq_bit;

  // z-score clip of the rounded quotient magnitude
  assign z_lim = (WW+1)'($unsigned(SMAX)) + (WW+1)'(d_neg);
  assign z_sat = (dv_quo > z_lim);
  assign zq    = $signed(VW'(dv_quo[SW:0]));
  always_comb begin
    if (z_sat) z_val = d_neg ? VW'(SMIN) : VW'(SMAX);
    else       z_val = d_neg ? -zq : zq;
  end

  // min-max: signed offset onto target_low, then saturate
  assign qm     = $signed(VW'(dv_quo[33:0]));
  assign mm_off = span[32] ? -qm : qm;
  assign mm_sum = VW'(target_low) + mm_off;
  always_comb begin
    mm_sat = 1'b0;
    mm_val = mm_sum;
    if (mm_sum > VW'(SMAX)) begin
      mm_val = VW'(SMAX);
      mm_sat = 1'b1;
    end else if (mm_sum < VW'(SMIN)) begin
      mm_val = VW'(SMIN);
      mm_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scaling_mode <= 1'b0;
      target_low   <= 32'sd0;
      target_high  <= 32'sd65536;
      count        <= '0;
      run_sum      <= '0;
      run_min      <= SMAX;
      run_max      <= SMIN;
      ovf          <= 1'b0;
      done         <= 1'b0;
      idx          <= '0;
      pass_z       <= 1'b0;
      zundef       <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          CFG_MODE:  scaling_mode <= cfg_data[0];
          CFG_TLOW:  target_low   <= cfg_data;
          CFG_THIGH: target_high  <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (count < CAP) begin
              count   <= count + CW'(1);
              run_sum <= run_sum + SUMW'(x_in);
              if (x_in < run_min) run_min <= x_in;
              if (x_in > run_max) run_max <= x_in;
            end else begin
              ovf <= 1'b1;
            end
            if (last) state <= S_START;
          end
        end

        S_START: begin
          idx     <= '0;
          var_acc <= '0;
          if (!scaling_mode && count < CW'(2)) begin
            zundef <= 1'b1;
            pass_z <= 1'b1;
          end else begin
            zundef <= 1'b0;
            pass_z <= scaling_mode;
          end
          state <= S_READ;
        end

        // store read lands in rdata at the end of this cycle
        S_READ: state <= S_DISP;

        S_DISP: begin
          m_acc <= '0;
          if (scaling_mode) begin
            if (run_max == run_min) begin
              res_val <= VW'(HALF_Q16);
              res_sat <= 1'b0;
              state   <= S_EMIT;
            end else begin
              m_a   <= WW'(diff);
              m_b   <= MBW'(span_mag);
              state <= S_MUL_MM;
            end
          end else if (zundef) begin
            res_val <= '0;
            res_sat <= 1'b0;
            state   <= S_EMIT;
          end else begin
            m_a   <= WW'(x_mag);
            m_b   <= MBW'(count);
            state <= S_MUL_NX;
          end
        end

        S_MUL_NX, S_MUL_DD, S_MUL_MM: begin
          if (m_b != '0) begin
            if (m_b[0]) m_acc <= m_acc + m_a;
            m_a <= m_a << 1;
            m_b <= m_b >> 1;
          end else begin
            dv_rem <= '0;
            dv_quo <= '0;
            dv_cnt <= '0;
            case (state)
              S_MUL_NX: begin
                d_val <= d_next;
                state <= S_CALC;
              end
              S_MUL_DD: begin
                var_acc <= var_sum;
                if (is_final) begin
                  dv_num <= (WW+1)'(var_sum);
                  dv_den <= (WW+1)'(count - CW'(1));
                  state  <= S_DIV_V;
                end else begin
                  idx   <= idx + 1'b1;
                  state <= S_READ;
                end
              end
              default: begin
                // round half away: (2p + r) / 2r
                dv_num <= (WW+1)'({m_acc, 1'b0}) + (WW+1)'(rng);
                dv_den <= (WW+1)'({rng, 1'b0});
                state  <= S_DIV_M;
              end
            endcase
          end
        end

        S_CALC: begin
          dv_rem <= '0;
          dv_quo <= '0;
          dv_cnt <= '0;
          m_acc  <= '0;
          if (pass_z) begin
            dv_num <= (WW+1)'({d_mag, 17'd0}) + (WW+1)'(root);
            dv_den <= (WW+1)'({root, 1'b0});
            state  <= S_DIV_Z;
          end else begin
            m_a   <= WW'(d_mag);
            m_b   <= MBW'(d_mag);
            state <= S_MUL_DD;
          end
        end

        S_DIV_V, S_DIV_Z, S_DIV_M: begin
          if (dv_cnt != DIV_STEPS) begin
            dv_rem <= dv_ge ? (rem_sh - {1'b0, dv_den}) : rem_sh;
            dv_quo <= {dv_quo[WW-1:0], dv_ge};
            dv_num <= dv_num << 1;
            dv_cnt <= dv_cnt + 1'b1;
          end else begin
            case (state)
              S_DIV_V: begin
                sq_n   <= dv_quo[WW-1:0];
                sq_res <= '0;
                sq_bit <= WW'(1) << (WW - 2);
                state  <= S_SQRT;
              end
              S_DIV_Z: begin
                res_val <= z_val;
                res_sat <= z_sat;
                state   <= S_EMIT;
              end
              default: begin
                res_val <= mm_val;
                res_sat <= mm_sat;
                state   <= S_EMIT;
              end
            endcase
          end
        end

        S_SQRT: begin
          if (sq_bit != '0) begin
            if (sq_n >= sq_t) begin
              sq_n   <= sq_n - sq_t;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else begin
            root   <= sq_res[RW-1:0];
            zundef <= (sq_res == '0);
            pass_z <= 1'b1;
            idx    <= '0;
            state  <= S_READ;
          end
        end

        S_EMIT: begin
          done         <= 1'b1;
          scaled_value <= res_val[31:0];
          final_res    <= is_final;
          if (zundef)       status <= ST_UNDEF;
          else if (ovf)     status <= ST_OVF;
          else if (res_sat) status <= ST_SAT;
          else              status <= ST_OK;
          if (is_final) begin
            // drop load state for the next column
            count   <= '0;
            run_sum <= '0;
            run_min <= SMAX;
            run_max <= SMIN;
            ovf     <= 1'b0;
            state   <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_READ;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/cmzn_checker.sv
// Port-level checks for the column normalizer core, and their bind.
// Uses cmzn_pkg for status codes.
module cmzn_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        last,
  input logic        busy,
  input logic        done,
  input logic [31:0] scaled_value,
  input logic [1:0]  status,
  input logic        final_res
);
  import cmzn_pkg::*;

  // a beat marked last starts the run
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last |=> busy) else $error("no run after last beat");

  // a plain load beat produces no result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last |=> !done) else $error("result on load beat");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    done && !final_res |-> busy) else $error("run ended early");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    done && final_res |-> !busy) else $error("busy after final result");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_UNDEF |-> scaled_value == 32'd0)
    else $error("undefined result not zero");

endmodule

bind column_minmax_zscore_normalizer_core cmzn_checker u_cmzn_checker (
  .clk(clk), .rst(rst), .start(start), .last(last), .busy(busy), .done(done),
  .scaled_value(scaled_value), .status(status), .final_res(final_res)
);
